// ===== rtl/core/edge_list_graph_table_macros.svh =====
// ----------------------------------------------------------------------------
// Edge list graph table assertion macros
// Shared assertion wrappers clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef EDGE_LIST_GRAPH_TABLE_MACROS_SVH
`define EDGE_LIST_GRAPH_TABLE_MACROS_SVH

// checked outside reset only
`define ELGT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ELGT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/elgt_pkg.sv =====
// ----------------------------------------------------------------------------
// Edge list graph table package
// Sizes, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package elgt_pkg;

   localparam int EDGE_CAPACITY = 32;
   localparam int MAX_VERTEX    = 16;

   localparam int ADDR_W     = $clog2(EDGE_CAPACITY);
   localparam int TOTAL_W    = $clog2(EDGE_CAPACITY + 1);
   localparam int VERT_W     = 5;
   localparam int ENTRY_W    = 2 * VERT_W;
   localparam int MODE_W     = 3;
   localparam int STAT_W     = 3;
   localparam int ANS_W      = 7;
   localparam int POL_W      = 2;
   localparam int VCNT_W     = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [STAT_W-1:0] status_type;
   typedef logic [POL_W-1:0]  policy_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam mode_type MODE_INSERT = 3'd0;
   localparam mode_type MODE_DEGREE = 3'd1;
   localparam mode_type MODE_ADJ    = 3'd2;
   localparam mode_type MODE_LIST   = 3'd3;
   localparam mode_type MODE_CLEAR  = 3'd4;

   localparam status_type STAT_OK    = 3'd0;
   localparam status_type STAT_DUP   = 3'd1;
   localparam status_type STAT_LOOP  = 3'd2;
   localparam status_type STAT_FULL  = 3'd3;
   localparam status_type STAT_QUERY = 3'd4;

   localparam policy_type POL_PLAIN      = 2'd0;
   localparam policy_type POL_DIRECTED   = 2'd1;
   localparam policy_type POL_UNDIRECTED = 2'd2;

   localparam csr_index_type REG_POLICY = 8'd0;
   localparam csr_index_type REG_VCOUNT = 8'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;   // capture the accepted request, restart the scan
      logic scan;   // walk the edge table
      logic emit;   // load one result into the output register
   } ctl_cmd_type;

   typedef struct packed {
      logic req_known;   // request mode is one of the defined operations
      logic scan_done;
      logic out_free;
      logic list_more;   // neighbors remain after the one being emitted
   } ctl_status_type;

endpackage

// ===== rtl/core/edge_list_graph_table.sv =====
// ----------------------------------------------------------------------------
// Edge list graph table
// Stores up to 32 directed edges and answers insert, degree, adjacency,
// neighbor list and clear requests.
// ----------------------------------------------------------------------------
// One request at a time. A request is accepted in ST_IDLE; ST_SCAN then
// reads each stored edge and waits while the last read returns (the edge
// memory has a single registered read port and is read one entry per
// cycle); ST_EMIT loads the result register before the next request is
// taken. Clear, plain inserts and inserts refused as loops skip the reads.
// A neighbor list then gives one result per cycle while the output is
// taken. Undefined modes are accepted and dropped without a result. The
// output register lets a result wait while the next request is accepted
// and scanned. No clearing pass follows reset; the edge count starts at
// zero.
module edge_list_graph_table (
   input  logic                             clock,
   input  logic                             reset,
   // request: mode[2:0], vertex_a[7:3], vertex_b[12:8], zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [elgt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // result: status[2:0], answer[9:3], zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [elgt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // result sideband: found[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // register writes: 0 insert_policy, 1 vertex_count
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [elgt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [elgt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import elgt_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type st;

   assign csr_ready = 1'b1;

   elgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   elgt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

// ===== rtl/core/elgt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module elgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/elgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Edge list graph table controller
// Sequences accept, table scan and result emission.
// ----------------------------------------------------------------------------
module elgt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  elgt_pkg::ctl_status_type st,
   output elgt_pkg::ctl_cmd_type    cmd
);
   import elgt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               // drop undefined modes without a result
               if (st.req_known) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (st.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (!st.list_more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/elgt_dpath.sv =====
// ----------------------------------------------------------------------------
// Edge list graph table datapath
// Edge memory, scan accumulators, registers and the output register.
// ----------------------------------------------------------------------------
module elgt_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [elgt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             csr_valid,
   input  logic [elgt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [elgt_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [elgt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  elgt_pkg::ctl_cmd_type            cmd,
   output elgt_pkg::ctl_status_type         st
);
   import elgt_pkg::*;

   localparam logic [ANS_W-1:0] DEG_MAX = '1;

   // configuration
   policy_type          policy_ff;
   logic [VCNT_W-1:0]   vcount_ff;

   // table fill level
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;

   // captured request
   mode_type            mode_ff;
   logic [VERT_W-1:0]   a_ff;
   logic [VERT_W-1:0]   b_ff;

   // scan
   logic [TOTAL_W-1:0]  idx_ff;
   logic [TOTAL_W-1:0]  idx_in;
   logic                rd_valid_ff;
   logic                rd_issue;
   logic                skip;
   logic                scan_done;
   logic [ENTRY_W-1:0]  ram_q;
   logic [VERT_W-1:0]   e_src;
   logic [VERT_W-1:0]   e_dst;
   logic                fwd;
   logic                rev;
   logic                pol_undir;
   logic                pol_plain;

   // accumulators
   logic                dup_ff;
   logic                dup_in;
   logic                adj_ff;
   logic                adj_in;
   logic [ANS_W-1:0]    deg_ff;
   logic [ANS_W-1:0]    deg_in;
   logic [ANS_W:0]      deg_sum;
   logic [MAX_VERTEX-1:0] mask_ff;
   logic [MAX_VERTEX-1:0] mask_in;
   logic [MAX_VERTEX-1:0] mask_hit;

   // result selection
   logic [MAX_VERTEX-1:0] limit;
   logic [MAX_VERTEX-1:0] lim;
   logic [MAX_VERTEX-1:0] rest;
   logic [ANS_W-1:0]    low_ans;
   status_type          ins_stat;
   status_type          res_stat;
   logic [ANS_W-1:0]    res_ans;
   logic                res_found;
   logic                res_last;
   logic                wr_en;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          rsp_stat_ff;
   logic [ANS_W-1:0]    rsp_ans_ff;
   logic                rsp_found_ff;
   logic                rsp_last_ff;

   assign pol_plain = (policy_ff == POL_PLAIN);
   assign pol_undir = policy_ff[1];   // code three behaves as undirected

   assign skip = (mode_ff == MODE_CLEAR) ||
                 ((mode_ff == MODE_INSERT) && (pol_plain || (pol_undir && (a_ff == b_ff))));
   assign scan_done = skip || (idx_ff >= total_ff);
   assign rd_issue  = cmd.scan && !scan_done;

   assign e_src = ram_q[ENTRY_W-1:VERT_W];
   assign e_dst = ram_q[VERT_W-1:0];
   assign fwd   = (e_src == a_ff) && (e_dst == b_ff);
   assign rev   = (e_src == b_ff) && (e_dst == a_ff);

   always_comb begin
      for (int j = 0; j < MAX_VERTEX; j++) begin
         mask_hit[j] = ((e_src == a_ff) && (int'(e_dst) == j + 1)) ||
                       ((e_dst == a_ff) && (int'(e_src) == j + 1));
         limit[j]    = (j < int'(vcount_ff));
      end
   end

   assign deg_sum = {1'b0, deg_ff} + (ANS_W+1)'(e_src == a_ff) + (ANS_W+1)'(e_dst == a_ff);

   // neighbor pick: lowest remaining vertex
   assign lim  = mask_ff & limit;
   assign rest = lim & (lim - 1'b1);

   always_comb begin
      low_ans = '0;
      for (int j = MAX_VERTEX - 1; j >= 0; j--) begin
         if (lim[j]) begin
            low_ans = ANS_W'(j + 1);
         end
      end
   end

   always_comb begin
      if (pol_undir && (a_ff == b_ff)) begin
         ins_stat = STAT_LOOP;
      end else if (dup_ff) begin
         ins_stat = STAT_DUP;
      end else if (total_ff >= TOTAL_W'(EDGE_CAPACITY)) begin
         ins_stat = STAT_FULL;
      end else begin
         ins_stat = STAT_OK;
      end
   end

   always_comb begin
      res_stat  = STAT_QUERY;
      res_ans   = '0;
      res_found = 1'b0;
      res_last  = 1'b1;
      unique case (mode_ff)
         MODE_INSERT: res_stat = ins_stat;
         MODE_DEGREE: res_ans  = deg_ff;
         MODE_ADJ:    res_ans  = ANS_W'(adj_ff);
         MODE_LIST: begin
            if (lim != '0) begin
               res_ans   = low_ans;
               res_found = 1'b1;
               res_last  = (rest == '0);
            end
         end
         default:     res_stat = STAT_OK;
      endcase
   end

   assign wr_en = cmd.emit && (mode_ff == MODE_INSERT) && (ins_stat == STAT_OK);

   elgt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (EDGE_CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[ADDR_W-1:0]),
      .wr_data ({a_ff, b_ff}),
      .rd_en   (rd_issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   always_comb begin
      idx_in  = idx_ff;
      dup_in  = dup_ff;
      adj_in  = adj_ff;
      deg_in  = deg_ff;
      mask_in = mask_ff;
      if (cmd.load) begin
         idx_in  = '0;
         dup_in  = 1'b0;
         adj_in  = 1'b0;
         deg_in  = '0;
         mask_in = '0;
      end else begin
         if (rd_issue) begin
            idx_in = idx_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            dup_in  = dup_ff | fwd | (pol_undir & rev);
            adj_in  = adj_ff | fwd | rev;
            deg_in  = (deg_sum > {1'b0, DEG_MAX}) ? DEG_MAX : deg_sum[ANS_W-1:0];
            mask_in = mask_ff | mask_hit;
         end
         if (cmd.emit) begin
            mask_in = rest;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (wr_en) begin
         total_in = total_ff + 1'b1;
      end else if (cmd.emit && (mode_ff == MODE_CLEAR)) begin
         total_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_DIRECTED;
         vcount_ff    <= VCNT_W'(MAX_VERTEX);
         total_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == REG_POLICY)) begin
            policy_ff <= csr_data[POL_W-1:0];
         end
         if (csr_valid && (csr_index == REG_VCOUNT)) begin
            vcount_ff <= csr_data[VCNT_W-1:0];
         end
         total_ff     <= total_in;
         rd_valid_ff  <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tdata[MODE_W-1:0];
         a_ff    <= req_tdata[MODE_W+VERT_W-1:MODE_W];
         b_ff    <= req_tdata[MODE_W+2*VERT_W-1:MODE_W+VERT_W];
      end
      idx_ff  <= idx_in;
      dup_ff  <= dup_in;
      adj_ff  <= adj_in;
      deg_ff  <= deg_in;
      mask_ff <= mask_in;
      if (cmd.emit) begin
         rsp_stat_ff  <= res_stat;
         rsp_ans_ff   <= res_ans;
         rsp_found_ff <= res_found;
         rsp_last_ff  <= res_last;
      end
   end

   assign st.req_known = (req_tdata[MODE_W-1:0] <= MODE_CLEAR);
   assign st.scan_done = scan_done;
   assign st.out_free  = !rsp_valid_ff || rsp_tready;
   assign st.list_more = (mode_ff == MODE_LIST) && (rest != '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-STAT_W-ANS_W)'(0), rsp_ans_ff, rsp_stat_ff};
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/elgt_checker.sv =====
// ----------------------------------------------------------------------------
// Edge list graph table port checker
// Watches the top-level ports for result ordering and encoding slips.
// ----------------------------------------------------------------------------
`include "edge_list_graph_table_macros.svh"

module elgt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [elgt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);
   import elgt_pkg::*;

   // a stalled result holds
   `ELGT_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   `ELGT_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_tvalid, "result valid right after reset")

   // a neighbor result is a query answer with a nonzero vertex
   `ELGT_ASSERT(a_found_query, rsp_tvalid && rsp_tuser |-> rsp_tdata[2:0] == STAT_QUERY && rsp_tdata[9:3] != 0, "found set on a non-neighbor result")

   // insert and clear outcomes are single, empty results
   `ELGT_ASSERT(a_update_single, rsp_tvalid && rsp_tdata[2:0] != STAT_QUERY |-> rsp_tlast && rsp_tdata[9:3] == 0 && !rsp_tuser, "update result not single or not empty")

   // no new request while a neighbor list is still running
   `ELGT_ASSERT(a_list_busy, rsp_tvalid && !rsp_tlast |-> !req_tready, "request taken inside a neighbor list")

endmodule

bind edge_list_graph_table elgt_checker u_elgt_checker (.*);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Edge list graph table testbench
// Drives insert, degree, adjacency, neighbor list and clear requests under
// every insert policy and several vertex counts, predicts each result from a
// shadow copy of the edge table and checks every result field in order.
// ----------------------------------------------------------------------------
module tb;
   import elgt_pkg::*;

   localparam int IDLE_MAX     = 17;
   localparam int DRAIN_CYCLES = 40;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PRINT_MAX    = 100;
   localparam int ANS_MAX      = (1 << ANS_W) - 1;

   // modes the block accepts and drops
   localparam mode_type MODE_UNUSED_FIRST = 3'd5;
   localparam mode_type MODE_UNUSED_LAST  = 3'd7;
   // register indexes that the block ignores
   localparam csr_index_type REG_NONE_LOW  = 8'd2;
   localparam csr_index_type REG_NONE_HIGH = 8'hFF;

   typedef logic [VERT_W-1:0] vertex_type;

   typedef struct {
      status_type          status;
      logic [ANS_W-1:0]    answer;
      logic                found;
      logic                last;
   } answer_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid;
   logic                      csr_ready;
   csr_index_type             csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   // shadow graph state
   vertex_type    tbl_src [EDGE_CAPACITY];
   vertex_type    tbl_dst [EDGE_CAPACITY];
   int            edge_cnt;
   policy_type    cur_policy;
   logic [VCNT_W-1:0] cur_vcount;

   answer_type    pending_answers[$];
   int            error_count;
   int            result_count;
   int            rsp_stall;
   int            quiet_cycles;
   bit            req_idle;
   bit            rsp_idle;

   edge_list_graph_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   task automatic report(string msg);
      if (error_count < PRINT_MAX) begin
         $display("ERROR result %0d: %s", result_count, msg);
      end
      error_count++;
   endtask

   function automatic bit linked(vertex_type x, vertex_type y);
      for (int i = 0; i < edge_cnt; i++) begin
         if ((tbl_src[i] == x && tbl_dst[i] == y) || (tbl_src[i] == y && tbl_dst[i] == x))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void push_answer(status_type st, int ans, logic fnd, logic lst);
      answer_type rec;
      rec.status = st;
      rec.answer = ans[ANS_W-1:0];
      rec.found  = fnd;
      rec.last   = lst;
      pending_answers.push_back(rec);
   endfunction

   function automatic void graph_predict(mode_type m, vertex_type a, vertex_type b);
      policy_type pol;
      status_type st;
      bit         dup;
      int         cnt;
      int         n;
      int         hits;
      case (m)
         MODE_INSERT: begin
            // the spare policy code behaves as undirected
            pol = (cur_policy > POL_UNDIRECTED) ? POL_UNDIRECTED : cur_policy;
            dup = 1'b0;
            for (int i = 0; i < edge_cnt; i++) begin
               if ((tbl_src[i] == a && tbl_dst[i] == b) ||
                   (pol == POL_UNDIRECTED && tbl_src[i] == b && tbl_dst[i] == a))
                  dup = 1'b1;
            end
            if (pol == POL_UNDIRECTED && a == b) begin
               st = STAT_LOOP;
            end else if (pol != POL_PLAIN && dup) begin
               st = STAT_DUP;
            end else if (edge_cnt >= EDGE_CAPACITY) begin
               st = STAT_FULL;
            end else begin
               tbl_src[edge_cnt] = a;
               tbl_dst[edge_cnt] = b;
               edge_cnt++;
               st = STAT_OK;
            end
            push_answer(st, 0, 1'b0, 1'b1);
         end
         MODE_DEGREE: begin
            cnt = 0;
            for (int i = 0; i < edge_cnt; i++) begin
               if (tbl_src[i] == a) cnt++;
               if (tbl_dst[i] == a) cnt++;
            end
            if (cnt > ANS_MAX) cnt = ANS_MAX;
            push_answer(STAT_QUERY, cnt, 1'b0, 1'b1);
         end
         MODE_ADJ: begin
            push_answer(STAT_QUERY, linked(a, b), 1'b0, 1'b1);
         end
         MODE_LIST: begin
            n = (cur_vcount > MAX_VERTEX) ? MAX_VERTEX : cur_vcount;
            hits = 0;
            for (int v = 1; v <= n; v++) begin
               if (linked(a, v[VERT_W-1:0])) begin
                  push_answer(STAT_QUERY, v, 1'b1, 1'b0);
                  hits++;
               end
            end
            if (hits == 0)
               push_answer(STAT_QUERY, 0, 1'b0, 1'b1);
            else
               pending_answers[pending_answers.size()-1].last = 1'b1;
         end
         MODE_CLEAR: begin
            edge_cnt = 0;
            push_answer(STAT_OK, 0, 1'b0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   task automatic send_req(mode_type m, vertex_type a, vertex_type b);
      int gap;
      gap = req_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(REQ_DATA_W-MODE_W-2*VERT_W){1'b0}}, b, a, m};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      graph_predict(m, a, b);
   endtask

   // hold requests until every expected result is back and the block is quiet
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      wait_drained();
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_POLICY)
         cur_policy = val[POL_W-1:0];
      else if (idx == REG_VCOUNT)
         cur_vcount = val[VCNT_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic vertex_type pick_vertex(int span);
      if ($urandom_range(0, 99) < 12)
         return vertex_type'($urandom_range(0, 31));
      return vertex_type'($urandom_range(1, span));
   endfunction

   task automatic test_basic_ops;
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      send_req(MODE_DEGREE, 1, vertex_type'($urandom));
      send_req(MODE_LIST, 1, vertex_type'($urandom));
      send_req(MODE_ADJ, 1, 2);
      send_req(MODE_INSERT, 1, 2);
      send_req(MODE_INSERT, 1, 2);
      send_req(MODE_INSERT, 2, 1);
      send_req(MODE_INSERT, 3, 3);
      send_req(MODE_INSERT, 16, 1);
      send_req(MODE_DEGREE, 3, vertex_type'($urandom));
      send_req(MODE_DEGREE, 1, vertex_type'($urandom));
      send_req(MODE_ADJ, 2, 1);
      send_req(MODE_LIST, 1, vertex_type'($urandom));
      send_req(MODE_LIST, 3, vertex_type'($urandom));
      // out-of-range vertex numbers are stored raw
      send_req(MODE_INSERT, 0, 31);
      send_req(MODE_DEGREE, 31, 0);
      send_req(MODE_ADJ, 31, 0);
      send_req(MODE_LIST, 0, 31);
      for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
         send_req(mode_type'(m), vertex_type'($urandom), vertex_type'($urandom));
      send_req(MODE_CLEAR, vertex_type'($urandom), vertex_type'($urandom));
      send_req(MODE_DEGREE, 1, 0);
      send_req(MODE_LIST, 1, 0);
   endtask

   task automatic test_policies;
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      write_reg(REG_POLICY, POL_UNDIRECTED);
      send_req(MODE_INSERT, 5, 5);
      send_req(MODE_INSERT, 5, 6);
      send_req(MODE_INSERT, 6, 5);
      send_req(MODE_INSERT, 16, 5);
      // spare policy code, upper data bits dropped
      write_reg(REG_POLICY, 8'hFF);
      send_req(MODE_INSERT, 7, 7);
      send_req(MODE_INSERT, 6, 5);
      send_req(MODE_INSERT, 5, 7);
      write_reg(REG_POLICY, 8'hFC);
      send_req(MODE_INSERT, 5, 6);
      send_req(MODE_INSERT, 8, 8);
      // ignored register indexes must leave the plain policy in force
      write_reg(REG_NONE_LOW, POL_UNDIRECTED);
      write_reg(REG_NONE_HIGH, 8'hFF);
      send_req(MODE_INSERT, 8, 8);
      send_req(MODE_DEGREE, 5, 0);
      write_reg(REG_VCOUNT, 0);
      send_req(MODE_LIST, 5, 0);
      write_reg(REG_VCOUNT, 1);
      send_req(MODE_LIST, 5, 0);
      write_reg(REG_VCOUNT, 31);
      send_req(MODE_LIST, 5, 0);
      write_reg(REG_VCOUNT, 8'hE6);
      send_req(MODE_LIST, 5, 0);
      write_reg(REG_VCOUNT, MAX_VERTEX);
      send_req(MODE_LIST, 5, 0);
      send_req(MODE_CLEAR, 0, 0);
   endtask

   task automatic test_capacity;
      vertex_type first_src;
      vertex_type first_dst;
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      write_reg(REG_POLICY, POL_PLAIN);
      // half the table as self-loops on vertex two, each counted twice in its degree
      for (int i = 0; i < EDGE_CAPACITY / 2; i++)
         send_req(MODE_INSERT, 2, 2);
      for (int i = 0; i < EDGE_CAPACITY / 2; i++)
         send_req(MODE_INSERT, 1, vertex_type'($urandom_range(1, MAX_VERTEX)));
      first_src = tbl_src[EDGE_CAPACITY/2];
      first_dst = tbl_dst[EDGE_CAPACITY/2];
      send_req(MODE_INSERT, 9, 10);
      send_req(MODE_INSERT, 2, 2);
      send_req(MODE_DEGREE, 2, 0);
      send_req(MODE_DEGREE, 1, 0);
      send_req(MODE_LIST, 1, 0);
      send_req(MODE_ADJ, 3, 1);
      // a duplicate or a loop is reported ahead of the full table
      write_reg(REG_POLICY, POL_DIRECTED);
      send_req(MODE_INSERT, first_src, first_dst);
      send_req(MODE_INSERT, 11, 12);
      write_reg(REG_POLICY, POL_UNDIRECTED);
      send_req(MODE_INSERT, 9, 9);
      send_req(MODE_INSERT, first_dst, first_src);
      send_req(MODE_INSERT, 13, 14);
      send_req(MODE_CLEAR, 0, 0);
      send_req(MODE_INSERT, 13, 14);
      send_req(MODE_CLEAR, 0, 0);
   endtask

   task automatic test_random_traffic;
      int span;
      int clear_pct;
      int pick;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(REG_POLICY, CSR_DATA_W'($urandom));
         case ($urandom_range(0, 5))
            0: write_reg(REG_VCOUNT, 0);
            1: write_reg(REG_VCOUNT, 1);
            2: write_reg(REG_VCOUNT, MAX_VERTEX);
            3: write_reg(REG_VCOUNT, 31);
            4: write_reg(REG_VCOUNT, CSR_DATA_W'($urandom));
            default: write_reg(REG_VCOUNT, CSR_DATA_W'($urandom_range(1, MAX_VERTEX)));
         endcase
         // first phase runs back to back on both sides
         req_idle  = (phase != 0) && ($urandom_range(0, 2) != 0);
         rsp_idle  = (phase != 0) && ($urandom_range(0, 2) != 0);
         span      = $urandom_range(3, MAX_VERTEX);
         clear_pct = $urandom_range(0, 1) ? 4 : 0;
         for (int k = 0; k < 30; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < clear_pct)
               send_req(MODE_CLEAR, vertex_type'($urandom), vertex_type'($urandom));
            else if (pick < 45)
               send_req(MODE_INSERT, pick_vertex(span), pick_vertex(span));
            else if (pick < 60)
               send_req(MODE_DEGREE, pick_vertex(span), vertex_type'($urandom));
            else if (pick < 75)
               send_req(MODE_ADJ, pick_vertex(span), pick_vertex(span));
            else if (pick < 96)
               send_req(MODE_LIST, pick_vertex(span), vertex_type'($urandom));
            else
               send_req(mode_type'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                        vertex_type'($urandom), vertex_type'($urandom));
         end
      end
   endtask

   // result side: random stalls, in-order compare
   always @(posedge clock) begin
      answer_type want;
      int         wait_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report("result arrived with nothing expected");
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[STAT_W-1:0] !== want.status)
               report($sformatf("status got %0d want %0d", rsp_tdata[STAT_W-1:0], want.status));
            if (rsp_tdata[STAT_W+ANS_W-1:STAT_W] !== want.answer)
               report($sformatf("answer got %0d want %0d",
                                rsp_tdata[STAT_W+ANS_W-1:STAT_W], want.answer));
            if (rsp_tuser !== want.found)
               report($sformatf("found got %b want %b", rsp_tuser, want.found));
            if (rsp_tlast !== want.last)
               report($sformatf("last got %b want %b", rsp_tlast, want.last));
         end
         result_count++;
         wait_n = rsp_idle ? $urandom_range(0, IDLE_MAX) : 0;
         rsp_tready <= (wait_n == 0);
         rsp_stall  <= wait_n;
      end else if (!rsp_tready) begin
         if (rsp_stall <= 1)
            rsp_tready <= 1'b1;
         else
            rsp_stall <= rsp_stall - 1;
      end
   end

   // watchdog: count cycles in which no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("edge_list_graph_table regression: fail");
            $finish;
         end
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      edge_cnt     = 0;
      cur_policy   = POL_DIRECTED;
      cur_vcount   = MAX_VERTEX;
      error_count  = 0;
      result_count = 0;
      req_idle     = 1'b0;
      rsp_idle     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_policies();
      test_capacity();
      test_random_traffic();

      wait_drained();
      if (error_count == 0 && pending_answers.size() == 0)
         $display("edge_list_graph_table regression: pass");
      else
         $display("edge_list_graph_table regression: fail");
      $finish;
   end

endmodule
